// ===== rtl/lfc_pkg.sv =====
// Shared types, constants and helpers for the lift floor controller.
package lfc_pkg;

    localparam int FLOORS   = 3;
    localparam int FLOOR_W  = 2;
    localparam int BTN_W    = 3;
    localparam int DELAY_W  = 16;
    localparam int HIST_W   = FLOORS + 1;

    localparam logic [DELAY_W-1:0] STEP_DELAY_RST  = 16'd2000;
    localparam logic [DELAY_W-1:0] ALARM_DELAY_RST = 16'd100;

    typedef enum logic [0:0] {
        CFG_STEP_DELAY  = 1'b0,
        CFG_ALARM_DELAY = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DIR_HOLD = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } t_dir;

    typedef struct packed {
        logic               alarm_active;
        logic [FLOOR_W-1:0] goal_floor;
        logic [FLOOR_W-1:0] car_floor;
        logic               buzzer;
        logic [BTN_W-1:0]   floor_leds;
    } t_result;

    function automatic t_dir lfc_heading(input logic [FLOOR_W-1:0] goal,
                                         input logic [FLOOR_W-1:0] car);
        t_dir d;
        if (goal > car) begin
            d = DIR_UP;
        end else if (goal < car) begin
            d = DIR_DOWN;
        end else begin
            d = DIR_HOLD;
        end
        return d;
    endfunction

endpackage

// ===== rtl/lfc_core.sv =====
// Per-tick state update: button edge scan, buzzer timing and car movement.
module lfc_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  logic [lfc_pkg::BTN_W-1:0]     i_floor_buttons,
    input  logic                          i_alarm_button,
    input  logic [lfc_pkg::DELAY_W-1:0]   i_step_delay,
    input  logic [lfc_pkg::DELAY_W-1:0]   i_alarm_delay,
    output lfc_pkg::t_result              o_result
);
    import lfc_pkg::*;

    logic [HIST_W-1:0]  r_hist,     n_hist;
    logic               r_alarm_on, n_alarm_on;
    logic               r_buzzer,   n_buzzer;
    logic [FLOOR_W-1:0] r_car,      n_car;
    logic [FLOOR_W-1:0] r_goal,     n_goal;
    logic [DELAY_W-1:0] r_move_cd,  n_move_cd;
    logic [DELAY_W-1:0] r_tog_cd,   n_tog_cd;

    always_comb begin
        logic found;
        logic lvl;
        t_dir prev_dir;
        t_dir dir;
        n_hist     = r_hist;
        n_alarm_on = r_alarm_on;
        n_buzzer   = r_buzzer;
        n_car      = r_car;
        n_goal     = r_goal;
        n_move_cd  = (r_move_cd != '0) ? r_move_cd - 1'b1 : '0;
        n_tog_cd   = (r_tog_cd != '0) ? r_tog_cd - 1'b1 : '0;
        found      = 1'b0;
        lvl        = 1'b0;
        prev_dir   = DIR_HOLD;

        n_hist[FLOORS] = i_alarm_button;
        if (i_alarm_button && !r_hist[FLOORS]) begin
            n_goal     = r_car;
            n_alarm_on = 1'b1;
        end else begin
            for (int i = 0; i < FLOORS; i++) begin
                if (!found) begin
                    lvl        = i_floor_buttons[i];
                    n_hist[i]  = lvl;
                    if (lvl && !r_hist[i]) begin
                        found      = 1'b1;
                        prev_dir   = lfc_heading(r_goal, r_car);
                        n_goal     = FLOOR_W'(i);
                        n_alarm_on = 1'b0;
                        n_buzzer   = 1'b0;
                        if (lfc_heading(n_goal, r_car) != prev_dir) begin
                            n_move_cd = i_step_delay;
                        end
                    end
                end
            end
        end

        if (n_alarm_on && n_tog_cd == '0) begin
            n_buzzer = ~n_buzzer;
            n_tog_cd = i_alarm_delay;
        end

        dir = lfc_heading(n_goal, r_car);
        if (dir != DIR_HOLD && n_move_cd == '0) begin
            n_car     = (dir == DIR_UP) ? r_car + 1'b1 : r_car - 1'b1;
            n_move_cd = i_step_delay;
        end
    end

    always_comb begin
        o_result.floor_leds   = BTN_W'(1) << n_car;
        o_result.buzzer       = n_buzzer;
        o_result.car_floor    = n_car;
        o_result.goal_floor   = n_goal;
        o_result.alarm_active = n_alarm_on;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist     <= '0;
            r_alarm_on <= 1'b0;
            r_buzzer   <= 1'b0;
            r_car      <= '0;
            r_goal     <= '0;
            r_move_cd  <= '0;
            r_tog_cd   <= '0;
        end else if (i_advance) begin
            r_hist     <= n_hist;
            r_alarm_on <= n_alarm_on;
            r_buzzer   <= n_buzzer;
            r_car      <= n_car;
            r_goal     <= n_goal;
            r_move_cd  <= n_move_cd;
            r_tog_cd   <= n_tog_cd;
        end
    end

    a_floor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_car < FLOOR_W'(FLOORS)) && (r_goal < FLOOR_W'(FLOORS)))
        else $error("car or goal floor out of range");

    a_quiet_buzzer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_alarm_on |-> !r_buzzer)
        else $error("buzzer on without alarm");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_advance |=> $stable(r_car) && $stable(r_goal) && $stable(r_move_cd))
        else $error("state changed without an item");

    a_step_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && (n_car != r_car) |=> r_move_cd == $past(i_step_delay))
        else $error("car stepped without countdown reload");

endmodule

// ===== rtl/lift_floor_controller_top.sv =====
// Lift floor controller top: stream ports, config registers, input and result stages.
// Output: m_axis_tvalid rises once the accepted item has moved from the input stage
// into the result stage.
// Throughput: one item per clock; a stalled output holds full stages, and s_axis_tready drops when both are full.
// Reset (i_rst_n low, synchronous): both stages empty, car and goal at floor 0,
// alarm and buzzer off, countdowns zero, step delay 2000, alarm delay 100.
module lift_floor_controller_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [2:0] floor_buttons, [3] alarm_button
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [2:0] floor_leds, [3] buzzer, [5:4] car_floor,
                                        // [7:6] goal_floor, [8] alarm_active
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);
    import lfc_pkg::*;

    logic [DELAY_W-1:0] r_step_delay;
    logic [DELAY_W-1:0] r_alarm_delay;
    logic               r_in_valid;
    logic [BTN_W-1:0]   r_in_buttons;
    logic               r_in_alarm;
    logic               r_out_valid;
    t_result            r_out;
    t_result            w_result;
    logic               w_advance;

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_delay  <= STEP_DELAY_RST;
            r_alarm_delay <= ALARM_DELAY_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_STEP_DELAY:  r_step_delay  <= i_cfg_wdata;
                CFG_ALARM_DELAY: r_alarm_delay <= i_cfg_wdata;
                default:         r_step_delay  <= r_step_delay;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_buttons <= s_axis_tdata[BTN_W-1:0];
            r_in_alarm   <= s_axis_tdata[BTN_W];
        end
    end

    lfc_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (w_advance),
        .i_floor_buttons (r_in_buttons),
        .i_alarm_button  (r_in_alarm),
        .i_step_delay    (r_step_delay),
        .i_alarm_delay   (r_alarm_delay),
        .o_result        (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = 16'(r_out);

endmodule
